// File: sv/ngga_pkg.sv
package ngga_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_SOUTH  = 8'h53;
  localparam logic [7:0] CH_WEST   = 8'h57;

  localparam logic [7:0] HDR_TEXT [5] = '{8'h47, 8'h4E, 8'h47, 8'h47, 8'h41};

  localparam logic [2:0] HP_IDLE  = 3'd0;
  localparam logic [2:0] HP_FIRST = 3'd1;
  localparam logic [2:0] HP_LAST  = 3'd5;
  localparam logic [2:0] HP_COMMA = 3'd6;

  localparam logic [3:0] FLD_NONE = 4'd0;
  localparam logic [3:0] FLD_TIME = 4'd1;
  localparam logic [3:0] FLD_LAT  = 4'd2;
  localparam logic [3:0] FLD_NS   = 4'd3;
  localparam logic [3:0] FLD_LON  = 4'd4;
  localparam logic [3:0] FLD_EW   = 4'd5;
  localparam logic [3:0] FLD_FIX  = 4'd6;
  localparam logic [3:0] FLD_SATS = 4'd7;
  localparam logic [3:0] FLD_HDOP = 4'd8;
  localparam logic [3:0] FLD_ALT  = 4'd9;
  localparam logic [3:0] FLD_LAST = 4'd14;
  localparam logic [3:0] FLD_CSUM = 4'd15;

  localparam logic [23:0] WHOLE_MAX = 24'hFFFFFF;
  localparam logic [42:0] LAT_MAX   = 43'd900000000;
  localparam logic [42:0] LON_MAX   = 43'd1800000000;

  function automatic logic [23:0] pow10(input logic [2:0] n);
    logic [23:0] r;
    unique case (n)
      3'd0: r = 24'd1;
      3'd1: r = 24'd10;
      3'd2: r = 24'd100;
      3'd3: r = 24'd1000;
      3'd4: r = 24'd10000;
      3'd5: r = 24'd100000;
      3'd6: r = 24'd1000000;
      default: r = 24'd10000000;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic        valid;
    logic        is_lon;
    logic [17:0] deg;
    logic [6:0]  rem;
    logic [23:0] macc;
    logic [2:0]  fds;
  } pos_req_t;

  typedef struct packed {
    logic        valid;
    logic        is_lon;
    logic [31:0] mag;
  } pos_wr_t;

endpackage

// File: sv/ngga_byte_if.sv
interface ngga_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: sv/ngga_fix_if.sv
interface ngga_fix_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] latitude_e7;
  logic signed [31:0] longitude_e7;
  logic signed [20:0] altitude_dm;
  logic [4:0]         utc_hours;
  logic [5:0]         utc_minutes;
  logic [5:0]         utc_seconds;
  logic [6:0]         utc_hundredths;
  logic [3:0]         fix_quality;
  logic [6:0]         satellites_used;
  logic [9:0]         hdop_tenths;
  logic [7:0]         checksum_received;
  logic               position_present;

  modport source (output valid, output latitude_e7, output longitude_e7, output altitude_dm,
                  output utc_hours, output utc_minutes, output utc_seconds,
                  output utc_hundredths, output fix_quality, output satellites_used,
                  output hdop_tenths, output checksum_received, output position_present,
                  input ready);
  modport sink (input valid, input latitude_e7, input longitude_e7, input altitude_dm,
                input utc_hours, input utc_minutes, input utc_seconds,
                input utc_hundredths, input fix_quality, input satellites_used,
                input hdop_tenths, input checksum_received, input position_present,
                output ready);
endinterface

// File: sv/ngga_pos_conv.sv
module ngga_pos_conv #(
  parameter int FRAC_DIGITS = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ngga_pkg::pos_req_t req_i,
  output ngga_pkg::pos_wr_t  wr_o
);

  localparam logic [23:0] FracScale  = ngga_pkg::pow10(3'(FRAC_DIGITS));
  localparam logic [23:0] PostScale  = ngga_pkg::pow10(3'(7 - FRAC_DIGITS));
  localparam logic [30:0] RecipSixty = 31'd1145324613;

  logic [53:0] macc_scaled;
  logic [53:0] frac_sum;
  logic [53:0] x_full;
  logic [41:0] deg_e7;

  logic        s1_valid_q;
  logic        s1_is_lon_q;
  logic [41:0] s1_deg_e7_q;
  logic [29:0] s1_x_q;

  logic [60:0] recip_prod;
  logic [42:0] sum;
  logic [42:0] limit;
  logic [42:0] capped;

  logic        wr_valid_q;
  logic        wr_is_lon_q;
  logic [31:0] wr_mag_q;

  always_comb begin
    macc_scaled = 54'(req_i.macc) * 54'(ngga_pkg::pow10(3'(FRAC_DIGITS) - req_i.fds));
    frac_sum    = 54'(req_i.rem) * 54'(FracScale) + macc_scaled;
    x_full      = frac_sum * 54'(PostScale);
    deg_e7      = 42'(req_i.deg) * 42'd10000000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_is_lon_q <= req_i.is_lon;
    s1_deg_e7_q <= deg_e7;
    s1_x_q      <= 30'(x_full);
  end

  // The minutes divided by sixty come from a reciprocal product.
  always_comb begin
    recip_prod = 61'(s1_x_q) * 61'(RecipSixty);
    sum        = 43'(s1_deg_e7_q) + 43'(recip_prod[60:36]);
    limit      = s1_is_lon_q ? ngga_pkg::LON_MAX : ngga_pkg::LAT_MAX;
    capped     = (sum > limit) ? limit : sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q <= 1'b0;
    end else begin
      wr_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_is_lon_q <= s1_is_lon_q;
    wr_mag_q    <= 32'(capped);
  end

  assign wr_o.valid  = wr_valid_q;
  assign wr_o.is_lon = wr_is_lon_q;
  assign wr_o.mag    = wr_mag_q;

endmodule

// File: sv/nmea_gga_sentence_parser.sv
// Channel  Dir  Word
// in_i     in   rx_byte: one sentence character
// out_o    out  one decoded GGA fix per sentence
//
// Characters are taken one per cycle while in_i.ready is high.
// A position field is converted in a two-stage pipeline; when the second checksum
// digit follows at once, the converted value is forwarded straight into the result.
// Input stalls only when a finishing character meets an unread result.
// Reset clears parser state and out_o.valid; the result registers are not reset.
module nmea_gga_sentence_parser #(
  parameter int MINUTE_FRACTION_DIGITS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ngga_byte_if.sink   in_i,
  ngga_fix_if.source  out_o
);

  localparam int MaccW = ($clog2(10 ** MINUTE_FRACTION_DIGITS) > 7) ?
                         $clog2(10 ** MINUTE_FRACTION_DIGITS) : 7;

  logic [7:0] c;
  logic       in_fire;
  logic       is_digit;
  logic [3:0] dval;
  logic       hex_ok;
  logic [3:0] hex_val;
  logic [2:0] frac_limit;
  logic       would_emit;
  logic       emit;

  logic             hdr_ok_q, hdr_ok_d;
  logic [2:0]       hdr_pos_q, hdr_pos_d;
  logic [3:0]       field_q, field_d;
  logic [3:0]       cif_q, cif_d;
  logic             in_frac_q, in_frac_d;
  logic [2:0]       fds_q, fds_d;
  logic [23:0]      whole_q, whole_d;
  logic [10:0]      top_q, top_d;
  logic [3:0]       dig_q [4];
  logic [3:0]       dig_d [4];
  logic [MaccW-1:0] macc_q, macc_d;
  logic             minus_q, minus_d;
  logic [7:0]       csum_q, csum_d;
  logic [1:0]       present_q, present_d;
  logic             lat_neg_q, lat_neg_d;
  logic             lon_neg_q, lon_neg_d;
  logic [30:0]      lat_mag_q;
  logic [31:0]      lon_mag_q;
  logic [20:0]      alt_q, alt_d;
  logic [4:0]       hours_q, hours_d;
  logic [5:0]       mins_q, mins_d;
  logic [5:0]       secs_q, secs_d;
  logic [6:0]       hund_q, hund_d;
  logic [3:0]       fix_q, fix_d;
  logic [6:0]       sats_q, sats_d;
  logic [9:0]       hdop_q, hdop_d;

  logic [27:0] whole_next;
  logic [27:0] tenths;
  logic [19:0] alt_mag;
  logic [6:0]  pair_hi;
  logic [6:0]  pair_lo;
  logic        do_clear;
  logic        do_idle;
  logic [30:0] lat_mag_now;
  logic [31:0] lon_mag_now;

  ngga_pkg::pos_req_t pos_req;
  ngga_pkg::pos_wr_t  pos_wr;

  logic        out_valid_q;
  logic [30:0] o_lat_q;
  logic [31:0] o_lon_q;
  logic [20:0] o_alt_q;
  logic [4:0]  o_hours_q;
  logic [5:0]  o_mins_q;
  logic [5:0]  o_secs_q;
  logic [6:0]  o_hund_q;
  logic [3:0]  o_fix_q;
  logic [6:0]  o_sats_q;
  logic [9:0]  o_hdop_q;
  logic [7:0]  o_csum_q;
  logic        o_present_q;

  assign c        = in_i.rx_byte;
  assign is_digit = (c >= ngga_pkg::CH_ZERO) && (c <= ngga_pkg::CH_NINE);
  assign dval     = 4'(c - ngga_pkg::CH_ZERO);

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    priority if (is_digit) begin
      hex_val = dval;
    end else if (c >= ngga_pkg::CH_UP_A && c <= ngga_pkg::CH_UP_F) begin
      hex_val = 4'(c - ngga_pkg::CH_UP_A + 8'd10);
    end else if (c >= ngga_pkg::CH_LO_A && c <= ngga_pkg::CH_LO_F) begin
      hex_val = 4'(c - ngga_pkg::CH_LO_A + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    priority if (field_q == ngga_pkg::FLD_LAT || field_q == ngga_pkg::FLD_LON) begin
      frac_limit = 3'(MINUTE_FRACTION_DIGITS);
    end else if (field_q == ngga_pkg::FLD_TIME) begin
      frac_limit = 3'd2;
    end else begin
      frac_limit = 3'd1;
    end
  end

  assign would_emit = (c != ngga_pkg::CH_DOLLAR) && hdr_ok_q &&
                      (field_q == ngga_pkg::FLD_CSUM) && hex_ok && (cif_q != 4'd0);
  assign in_i.ready = !out_valid_q || out_o.ready || !would_emit;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    hdr_ok_d  = hdr_ok_q;
    hdr_pos_d = hdr_pos_q;
    field_d   = field_q;
    cif_d     = cif_q;
    in_frac_d = in_frac_q;
    fds_d     = fds_q;
    whole_d   = whole_q;
    top_d     = top_q;
    dig_d     = dig_q;
    macc_d    = macc_q;
    minus_d   = minus_q;
    csum_d    = csum_q;
    present_d = present_q;
    lat_neg_d = lat_neg_q;
    lon_neg_d = lon_neg_q;
    alt_d     = alt_q;
    hours_d   = hours_q;
    mins_d    = mins_q;
    secs_d    = secs_q;
    hund_d    = hund_q;
    fix_d     = fix_q;
    sats_d    = sats_q;
    hdop_d    = hdop_q;
    do_clear  = 1'b0;
    do_idle   = 1'b0;
    emit      = 1'b0;

    pos_req        = '0;
    pos_req.is_lon = (field_q == ngga_pkg::FLD_LON);
    pos_req.deg    = 18'(top_q) * 18'd100 + 18'(dig_q[3]) * 18'd10 + 18'(dig_q[2]);
    pos_req.rem    = 7'(dig_q[1]) * 7'd10 + 7'(dig_q[0]);
    pos_req.macc   = 24'(macc_q);
    pos_req.fds    = fds_q;

    whole_next = 28'(whole_q) * 28'd10 + 28'(dval);
    tenths     = 28'(whole_q) * 28'd10 + ((fds_q != 3'd0) ? 28'(macc_q) : 28'd0);
    pair_hi    = 7'(dig_q[3]) * 7'd10 + 7'(dig_q[2]);
    pair_lo    = 7'(dig_q[1]) * 7'd10 + 7'(dig_q[0]);
    alt_mag    = 20'd0;

    if (in_fire) begin
      if (c == ngga_pkg::CH_DOLLAR) begin
        hdr_ok_d  = 1'b0;
        hdr_pos_d = ngga_pkg::HP_FIRST;
        field_d   = ngga_pkg::FLD_NONE;
        csum_d    = 8'd0;
        present_d = 2'b00;
        do_clear  = 1'b1;
      end else if (!hdr_ok_q) begin
        if (hdr_pos_q >= ngga_pkg::HP_FIRST && hdr_pos_q <= ngga_pkg::HP_LAST) begin
          hdr_pos_d = (c == ngga_pkg::HDR_TEXT[hdr_pos_q - ngga_pkg::HP_FIRST]) ?
                      hdr_pos_q + 3'd1 : ngga_pkg::HP_IDLE;
        end else if (hdr_pos_q == ngga_pkg::HP_COMMA) begin
          if (c == ngga_pkg::CH_COMMA) begin
            hdr_ok_d = 1'b1;
            field_d  = ngga_pkg::FLD_TIME;
            do_clear = 1'b1;
          end else begin
            hdr_pos_d = ngga_pkg::HP_IDLE;
          end
        end
      end else if (field_q == ngga_pkg::FLD_CSUM) begin
        if (!hex_ok) begin
          do_idle = 1'b1;
        end else if (cif_q == 4'd0) begin
          csum_d = {csum_q[3:0], hex_val};
          cif_d  = 4'd1;
        end else begin
          emit    = 1'b1;
          do_idle = 1'b1;
        end
      end else if (c == ngga_pkg::CH_STAR || c == ngga_pkg::CH_COMMA) begin
        if (cif_q != 4'd0) begin
          unique case (field_q)
            ngga_pkg::FLD_TIME: begin
              hours_d = (top_q > 11'd23) ? 5'd23 : 5'(top_q);
              mins_d  = (pair_hi > 7'd59) ? 6'd59 : 6'(pair_hi);
              secs_d  = (pair_lo > 7'd59) ? 6'd59 : 6'(pair_lo);
              hund_d  = (fds_q == 3'd2) ? 7'(macc_q) :
                        (fds_q == 3'd1) ? 7'(7'(macc_q) * 7'd10) : 7'd0;
            end
            ngga_pkg::FLD_LAT: begin
              pos_req.valid = 1'b1;
              present_d[0]  = 1'b1;
              lat_neg_d     = 1'b0;
            end
            ngga_pkg::FLD_LON: begin
              pos_req.valid = 1'b1;
              present_d[1]  = 1'b1;
              lon_neg_d     = 1'b0;
            end
            ngga_pkg::FLD_FIX: begin
              fix_d = (whole_q > 24'd9) ? 4'd9 : 4'(whole_q);
            end
            ngga_pkg::FLD_SATS: begin
              sats_d = (whole_q > 24'd99) ? 7'd99 : 7'(whole_q);
            end
            ngga_pkg::FLD_HDOP: begin
              hdop_d = (tenths > 28'd999) ? 10'd999 : 10'(tenths);
            end
            ngga_pkg::FLD_ALT: begin
              if (minus_q) begin
                alt_mag = (tenths > 28'd99999) ? 20'd99999 : 20'(tenths);
                alt_d   = 21'(-$signed({1'b0, alt_mag}));
              end else begin
                alt_mag = (tenths > 28'd999999) ? 20'd999999 : 20'(tenths);
                alt_d   = {1'b0, alt_mag};
              end
            end
            default: begin
            end
          endcase
        end
        do_clear = 1'b1;
        if (c == ngga_pkg::CH_STAR) begin
          field_d = ngga_pkg::FLD_CSUM;
          csum_d  = 8'd0;
        end else if (field_q < ngga_pkg::FLD_LAST) begin
          field_d = field_q + 4'd1;
        end
      end else begin
        if (cif_q == 4'd0) begin
          if (field_q == ngga_pkg::FLD_NS && c == ngga_pkg::CH_SOUTH && present_q[0]) begin
            lat_neg_d = 1'b1;
          end
          if (field_q == ngga_pkg::FLD_EW && c == ngga_pkg::CH_WEST && present_q[1]) begin
            lon_neg_d = 1'b1;
          end
        end
        if (cif_q != 4'd15) begin
          cif_d = cif_q + 4'd1;
        end
        priority if (is_digit) begin
          if (in_frac_q) begin
            if (fds_q < frac_limit) begin
              macc_d = MaccW'(macc_q * MaccW'(10) + MaccW'(dval));
              fds_d  = fds_q + 3'd1;
            end
          end else if (whole_next > 28'(ngga_pkg::WHOLE_MAX)) begin
            whole_d = ngga_pkg::WHOLE_MAX;
            top_d   = 11'd1677;
            dig_d   = '{4'd5, 4'd1, 4'd2, 4'd7};
          end else begin
            whole_d  = 24'(whole_next);
            top_d    = 11'(15'(top_q) * 15'd10 + 15'(dig_q[3]));
            dig_d[3] = dig_q[2];
            dig_d[2] = dig_q[1];
            dig_d[1] = dig_q[0];
            dig_d[0] = dval;
          end
        end else if (c == ngga_pkg::CH_DOT) begin
          in_frac_d = 1'b1;
        end else if (c == ngga_pkg::CH_MINUS && field_q == ngga_pkg::FLD_ALT) begin
          minus_d = 1'b1;
        end
      end
    end

    if (do_idle) begin
      hdr_ok_d  = 1'b0;
      hdr_pos_d = ngga_pkg::HP_IDLE;
      field_d   = ngga_pkg::FLD_NONE;
      csum_d    = 8'd0;
      do_clear  = 1'b1;
    end
    if (do_clear) begin
      cif_d     = 4'd0;
      in_frac_d = 1'b0;
      fds_d     = 3'd0;
      whole_d   = 24'd0;
      top_d     = 11'd0;
      dig_d     = '{4'd0, 4'd0, 4'd0, 4'd0};
      macc_d    = '0;
      minus_d   = 1'b0;
    end
  end

  ngga_pos_conv #(
    .FRAC_DIGITS (MINUTE_FRACTION_DIGITS)
  ) u_pos_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (pos_req),
    .wr_o   (pos_wr)
  );

  assign lat_mag_now = (pos_wr.valid && !pos_wr.is_lon) ? 31'(pos_wr.mag) : lat_mag_q;
  assign lon_mag_now = (pos_wr.valid && pos_wr.is_lon) ? pos_wr.mag : lon_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_ok_q    <= 1'b0;
      hdr_pos_q   <= ngga_pkg::HP_IDLE;
      field_q     <= ngga_pkg::FLD_NONE;
      cif_q       <= 4'd0;
      in_frac_q   <= 1'b0;
      fds_q       <= 3'd0;
      whole_q     <= 24'd0;
      top_q       <= 11'd0;
      dig_q       <= '{4'd0, 4'd0, 4'd0, 4'd0};
      macc_q      <= '0;
      minus_q     <= 1'b0;
      csum_q      <= 8'd0;
      present_q   <= 2'b00;
      lat_neg_q   <= 1'b0;
      lon_neg_q   <= 1'b0;
      lat_mag_q   <= 31'd0;
      lon_mag_q   <= 32'd0;
      alt_q       <= 21'd0;
      hours_q     <= 5'd0;
      mins_q      <= 6'd0;
      secs_q      <= 6'd0;
      hund_q      <= 7'd0;
      fix_q       <= 4'd0;
      sats_q      <= 7'd0;
      hdop_q      <= 10'd0;
      out_valid_q <= 1'b0;
    end else begin
      hdr_ok_q  <= hdr_ok_d;
      hdr_pos_q <= hdr_pos_d;
      field_q   <= field_d;
      cif_q     <= cif_d;
      in_frac_q <= in_frac_d;
      fds_q     <= fds_d;
      whole_q   <= whole_d;
      top_q     <= top_d;
      dig_q     <= dig_d;
      macc_q    <= macc_d;
      minus_q   <= minus_d;
      csum_q    <= csum_d;
      present_q <= present_d;
      lat_neg_q <= lat_neg_d;
      lon_neg_q <= lon_neg_d;
      alt_q     <= alt_d;
      hours_q   <= hours_d;
      mins_q    <= mins_d;
      secs_q    <= secs_d;
      hund_q    <= hund_d;
      fix_q     <= fix_d;
      sats_q    <= sats_d;
      hdop_q    <= hdop_d;
      if (pos_wr.valid && !pos_wr.is_lon) begin
        lat_mag_q <= 31'(pos_wr.mag);
      end
      if (pos_wr.valid && pos_wr.is_lon) begin
        lon_mag_q <= pos_wr.mag;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_lat_q     <= lat_neg_q ? 31'(-$signed({1'b0, lat_mag_now})) : lat_mag_now;
      o_lon_q     <= lon_neg_q ? 32'(-$signed({1'b0, lon_mag_now})) : lon_mag_now;
      o_alt_q     <= alt_q;
      o_hours_q   <= hours_q;
      o_mins_q    <= mins_q;
      o_secs_q    <= secs_q;
      o_hund_q    <= hund_q;
      o_fix_q     <= fix_q;
      o_sats_q    <= sats_q;
      o_hdop_q    <= hdop_q;
      o_csum_q    <= {csum_q[3:0], hex_val};
      o_present_q <= (present_q == 2'b11);
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.latitude_e7       = $signed(o_lat_q);
  assign out_o.longitude_e7      = $signed(o_lon_q);
  assign out_o.altitude_dm       = $signed(o_alt_q);
  assign out_o.utc_hours         = o_hours_q;
  assign out_o.utc_minutes       = o_mins_q;
  assign out_o.utc_seconds       = o_secs_q;
  assign out_o.utc_hundredths    = o_hund_q;
  assign out_o.fix_quality       = o_fix_q;
  assign out_o.satellites_used   = o_sats_q;
  assign out_o.hdop_tenths       = o_hdop_q;
  assign out_o.checksum_received = o_csum_q;
  assign out_o.position_present  = o_present_q;

  a_field_when_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_ok_q |-> (field_q != ngga_pkg::FLD_NONE))
    else $error("open sentence without a field number");

  a_frac_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frac_q |-> (fds_q == 3'd0))
    else $error("fraction digits counted outside a fraction");

  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_fire))
    else $error("result appeared without an accepted word");

  a_idle_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (!hdr_ok_q && hdr_pos_q == ngga_pkg::HP_IDLE))
    else $error("parser not idle after a result");

endmodule
